>>> src/bucket_doubly_linked_lists_macros.svh
// ----------------------------------------------------------------------------
// Bucket doubly linked lists: assertion macros
// Immediate-edge and next-edge property shorthands on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef BUCKET_DOUBLY_LINKED_LISTS_MACROS_SVH
`define BUCKET_DOUBLY_LINKED_LISTS_MACROS_SVH

// antecedent implies consequent at the same edge
`define BDLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent at the next edge
`define BDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bdll_pkg.sv
// ----------------------------------------------------------------------------
// Bucket doubly linked lists: package
// Request codes, fixed field widths and the link memory control group.
// ----------------------------------------------------------------------------
package bdll_pkg;

  localparam int REQ_W  = 2;
  localparam int NODE_W = 10;
  localparam int BKT_W  = 8;
  localparam int HEAD_W = 11;

  localparam logic [REQ_W-1:0] OP_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] OP_MOVE   = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic we_next;
    logic we_prev;
  } bdll_lk_ctl_t;

endpackage

>>> src/bdll_link_mem.sv
// ----------------------------------------------------------------------------
// Bucket doubly linked lists: link memory
// One word per node holding {next, prev}; per-half write enables, one
// registered read port.
// ----------------------------------------------------------------------------
module bdll_link_mem
  import bdll_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  bdll_lk_ctl_t  ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_next,
  input  logic [DW-1:0] wr_prev,
  output logic [DW-1:0] rd_next,
  output logic [DW-1:0] rd_prev
);

  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.we_next) mem[wr_addr][2*DW-1:DW] <= wr_next;
    if (ctl.we_prev) mem[wr_addr][DW-1:0]    <= wr_prev;
    if (ctl.rd_en)   rd_q_r                  <= mem[rd_addr];
  end

  assign rd_next = rd_q_r[2*DW-1:DW];
  assign rd_prev = rd_q_r[DW-1:0];

endmodule

>>> src/bucket_doubly_linked_lists.sv
// Request path: S_UL1, S_UL2, S_PS1, S_PS2, then the result beat is registered; S_PS2
//   holds as long as out_ready stays low while an earlier result beat waits.
// One request at a time, taken only in S_IDLE; the four link updates of a move share the
//   single write port of the link memory and are done one per cycle.
// Reset: rst_n synchronous, active low; afterwards a clearing pass over all BUCKET_COUNT
//   bucket heads sets each to NIL, with in_ready low throughout.
// ----------------------------------------------------------------------------
// Bucket doubly linked lists: top level
// Node pool threaded on per-bucket doubly linked lists; add, remove and move
// requests, each answered with the new heads of the buckets involved.
// ----------------------------------------------------------------------------
module bucket_doubly_linked_lists
  import bdll_pkg::*;
#(
  parameter int NODE_COUNT   = 1024,
  parameter int BUCKET_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [NODE_W-1:0] in_node,
  input  logic [BKT_W-1:0]  in_bucket,
  input  logic [BKT_W-1:0]  in_from_bucket,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HEAD_W-1:0] out_head_of_bucket,
  output logic [HEAD_W-1:0] out_head_of_source
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKET_COUNT - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UL1  = 3'd2;
  localparam logic [2:0] S_UL2  = 3'd3;
  localparam logic [2:0] S_PS1  = 3'd4;
  localparam logic [2:0] S_PS2  = 3'd5;

  function automatic logic [LW-1:0] clean_f(input logic [LW-1:0] v);
    return (v >= NIL) ? NIL : v;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [BW-1:0]     clr_r;

  logic [REQ_W-1:0]  op_r;
  logic [NODE_W-1:0] node_r;
  logic [BKT_W-1:0]  b_r, fb_r;
  logic              b_ok_r, fb_ok_r, same_b_r, do_ul_r, do_push_r;
  logic [LW-1:0]     nx_r, pv_r, hb_r, hfb_r, h_r;

  logic              out_valid_r;
  logic [HEAD_W-1:0] out_hob_r, out_hos_r;

  bdll_lk_ctl_t      lk_ctl;
  logic [NW-1:0]     lk_ra, lk_wa;
  logic [LW-1:0]     lk_wn, lk_wp, lk_rn, lk_rp;

  logic              hd_re, hd_we;
  logic [BW-1:0]     hd_ra, hd_wa;
  logic [LW-1:0]     hd_wd, hd_q_r;
  logic [LW-1:0]     head_mem [BUCKET_COUNT];

  logic              in_fire, out_free;
  logic              node_ok, b_ok, fb_ok, is_move, pv_nil;
  logic [LW-1:0]     nx_c, pv_c, hd_c, node_lk;
  logic [LW-1:0]     hob_val, hos_val;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign node_ok = (int'(in_node) < NODE_COUNT);
  assign b_ok    = (int'(in_bucket) < BUCKET_COUNT);
  assign fb_ok   = (int'(in_from_bucket) < BUCKET_COUNT);
  assign is_move = (in_req_type == OP_MOVE);

  assign nx_c    = clean_f(lk_rn);
  assign pv_c    = clean_f(lk_rp);
  assign hd_c    = clean_f(hd_q_r);
  assign node_lk = LW'(node_r);
  assign pv_nil  = (pv_r == NIL);

  bdll_link_mem #(
    .DEPTH(NODE_COUNT),
    .AW   (NW),
    .DW   (LW)
  ) u_lk (
    .clk    (clk),
    .ctl    (lk_ctl),
    .rd_addr(lk_ra),
    .wr_addr(lk_wa),
    .wr_next(lk_wn),
    .wr_prev(lk_wp),
    .rd_next(lk_rn),
    .rd_prev(lk_rp)
  );

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (hd_re) hd_q_r <= head_mem[hd_ra];
  end

  // memory control
  always_comb begin
    state_nxt = state_r;
    lk_ctl    = '0;
    lk_ra     = NW'(in_node);
    lk_wa     = NW'(node_r);
    lk_wn     = h_r;
    lk_wp     = NIL;
    hd_re     = 1'b0;
    hd_ra     = BW'(in_bucket);
    hd_we     = 1'b0;
    hd_wa     = BW'(b_r);
    hd_wd     = node_lk;
    case (state_r)
      S_CLR: begin
        hd_we = 1'b1;
        hd_wa = clr_r;
        hd_wd = NIL;
        if (clr_r == LAST_BKT) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          lk_ctl.rd_en = 1'b1;
          hd_re        = 1'b1;
          state_nxt    = S_UL1;
        end
      end
      S_UL1: begin
        // prev[nx] = pv; head of source = nx when n was its head
        lk_ctl.we_prev = do_ul_r && (nx_c != NIL);
        lk_wa          = NW'(nx_c);
        lk_wp          = pv_c;
        hd_we          = do_ul_r && (pv_c == NIL);
        hd_wa          = (op_r == OP_MOVE) ? BW'(fb_r) : BW'(b_r);
        hd_wd          = nx_c;
        hd_re          = 1'b1;
        hd_ra          = BW'(fb_r);
        state_nxt      = S_UL2;
      end
      S_UL2: begin
        lk_ctl.we_next = do_ul_r && !pv_nil;
        lk_wa          = NW'(pv_r);
        lk_wn          = nx_r;
        state_nxt      = S_PS1;
      end
      S_PS1: begin
        lk_ctl.we_prev = do_push_r && (h_r != NIL);
        lk_wa          = NW'(h_r);
        lk_wp          = node_lk;
        hd_we          = do_push_r;
        state_nxt      = S_PS2;
      end
      S_PS2: begin
        lk_ctl.we_next = do_push_r;
        lk_ctl.we_prev = do_push_r;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign hob_val = !b_ok_r ? NIL :
                   do_push_r ? node_lk :
                   (do_ul_r && pv_nil) ? nx_r : hb_r;
  assign hos_val = !((op_r == OP_MOVE) && fb_ok_r) ? NIL :
                   (do_push_r && same_b_r) ? node_lk : hfb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_PS2 && out_free) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= in_req_type;
      node_r    <= in_node;
      b_r       <= in_bucket;
      fb_r      <= in_from_bucket;
      b_ok_r    <= b_ok;
      fb_ok_r   <= fb_ok;
      same_b_r  <= (in_bucket == in_from_bucket);
      do_ul_r   <= node_ok && b_ok && ((in_req_type == OP_REMOVE) || (is_move && fb_ok));
      do_push_r <= node_ok && b_ok && ((in_req_type == OP_ADD) || (is_move && fb_ok));
    end
    if (state_r == S_UL1) begin
      nx_r <= nx_c;
      pv_r <= pv_c;
      hb_r <= hd_c;
    end
    if (state_r == S_UL2) begin
      hfb_r <= (do_ul_r && pv_nil) ? nx_r : hd_c;
      h_r   <= (do_ul_r && pv_nil && ((op_r == OP_REMOVE) || same_b_r)) ? nx_r : hb_r;
    end
    if (state_r == S_PS2 && out_free) begin
      out_hob_r <= HEAD_W'(hob_val);
      out_hos_r <= HEAD_W'(hos_val);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_head_of_bucket = out_hob_r;
  assign out_head_of_source = out_hos_r;

endmodule

>>> src/bdll_checker.sv
// ----------------------------------------------------------------------------
// Bucket doubly linked lists: port checker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`include "bucket_doubly_linked_lists_macros.svh"

module bdll_checker
  import bdll_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HEAD_W-1:0] out_head_of_bucket,
  input logic [HEAD_W-1:0] out_head_of_source
);

  logic [1:0] pend_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_fire && !out_fire) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_fire && !in_fire) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  `BDLL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_head_of_bucket) && $stable(out_head_of_source),
    "result beat changed while stalled")

  `BDLL_ASSERT_NOW(a_no_phantom, out_valid, pend_r != 2'd0,
    "result beat without a pending request")

  `BDLL_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready,
    "request beats taken on consecutive cycles")

  `BDLL_ASSERT_NOW(a_clear_after_reset, $rose(rst_n), !in_ready && !out_valid,
    "block ready before head clearing")

endmodule

bind bucket_doubly_linked_lists bdll_checker u_bdll_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_head_of_bucket(out_head_of_bucket),
  .out_head_of_source(out_head_of_source)
);
